// File: hdl/gwr_pkg.sv
// ----------------------------------------------------------------------------
// gwr_pkg
// Shared types and constants for the greedy word wrap block.
// ----------------------------------------------------------------------------
package gwr_pkg;

   localparam int MAX_WORD_DEF = 48;
   localparam logic [7:0] LINE_WIDTH_RST = 8'd80;

   localparam logic [7:0] CHAR_TAB     = 8'd9;
   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_CR      = 8'd13;
   localparam logic [7:0] CHAR_SPACE   = 8'd32;

   typedef enum logic [2:0] {
      EMIT_IDLE,
      EMIT_SEP,
      EMIT_READ,
      EMIT_WORD,
      EMIT_TAIL
   } emit_state_type;

   // one flush handed from intake to the emitter
   typedef struct packed {
      logic       start;
      logic [1:0] sep_count;
      logic       sep_newline;
      logic       overlong;
      logic       exceeded;
   } flush_job_type;

endpackage

// File: hdl/greedy_text_word_wrap.sv
// ----------------------------------------------------------------------------
// greedy_text_word_wrap
// Greedy word wrap of a byte stream into lines of at most line_width chars; an overlong word still goes out.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one text byte per item with an end_of_text mark; rsp_*
//   carries the rewrapped bytes with a last-of-item mark and the sticky
//   exceeded flag. Both channels hand over on valid high and stall low.
//   csr_* writes line_width (always ready); write only while the block idles.
// Sequencing:
//   an item that does not end a word only updates the intake state. An item that
//   ends a word holds req_stall high while the sequencer plays out the
//   result: each separator byte, then each word byte (RAM read, then load
//   of the result register), then a trailing newline after an overlong
//   word. The first result reaches the output register through the SEP
//   state when a separator leads it, through READ and WORD otherwise.
// Stall and reset:
//   a stalled result holds in the output register and the sequencer waits.
//   Reset clears the word, column, gap and flags and sets line_width to 80.
//   After an overlong word all items are taken and dropped until reset.
// ----------------------------------------------------------------------------
module greedy_text_word_wrap import gwr_pkg::*; #(
   parameter int MAX_WORD = MAX_WORD_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_char,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_run_last,
   output logic       rsp_word_exceeded,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_line_width
);

   localparam int IDX_W = $clog2(MAX_WORD);
   localparam int LEN_W = $clog2(MAX_WORD + 1);
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_WORD);

   logic [7:0]       line_width_ff;
   logic [LEN_W-1:0] word_length_ff, word_length_in;
   logic [7:0]       column_ff, column_in;
   logic [1:0]       gap_ff, gap_in;
   logic             stopped_ff, stopped_in;
   logic             overflow_ff, overflow_in;

   logic             accept;
   logic             blank;
   logic             buf_full;
   logic             ram_we;
   logic [LEN_W-1:0] flush_len;
   logic             do_flush;
   logic [9:0]       fit_sum;
   logic             overlong;
   logic [7:0]       col_sep;
   logic [1:0]       gap_base;
   flush_job_type    job;
   logic             emit_busy;
   logic [IDX_W-1:0] rd_addr;
   logic [7:0]       rd_data;

   assign accept   = req_valid && !req_stall;
   assign blank    = (req_in_char == CHAR_SPACE) || (req_in_char inside {[CHAR_TAB:CHAR_CR]});
   assign buf_full = word_length_ff >= MAX_LEN;
   assign ram_we   = accept && !stopped_ff && !blank && !buf_full;

   // length of the word as the flush sees it
   assign flush_len = (blank || buf_full) ? word_length_ff : word_length_ff + LEN_W'(1);
   assign do_flush  = accept && !stopped_ff && (blank || req_end_of_text)
                      && flush_len != '0;
   assign fit_sum   = {2'b00, column_ff} + 10'd1 + 10'(flush_len);
   assign overlong  = 10'(flush_len) > {2'b00, line_width_ff};

   always_comb begin
      job             = '0;
      job.start       = do_flush;
      job.overlong    = overlong;
      job.exceeded    = overflow_ff || (!blank && buf_full) || overlong;
      col_sep         = 8'd0;
      if (column_ff != 8'd0) begin
         if (gap_ff >= 2'd2) begin
            job.sep_count   = 2'd2;
            job.sep_newline = 1'b1;
         end else if (fit_sum <= {2'b00, line_width_ff}) begin
            job.sep_count   = 2'd1;
            job.sep_newline = 1'b0;
            col_sep         = column_ff + 8'd1;
         end else begin
            job.sep_count   = 2'd1;
            job.sep_newline = 1'b1;
         end
      end
   end

   always_comb begin
      word_length_in = word_length_ff;
      column_in      = column_ff;
      gap_in         = gap_ff;
      stopped_in     = stopped_ff;
      overflow_in    = overflow_ff;
      gap_base       = do_flush ? 2'd0 : gap_ff;
      if (accept && !stopped_ff) begin
         if (!blank) begin
            if (buf_full) begin
               overflow_in = 1'b1;
            end else begin
               word_length_in = word_length_ff + LEN_W'(1);
            end
            if (req_end_of_text) begin
               gap_in = 2'd0;
            end
         end else if (req_end_of_text) begin
            gap_in = 2'd0;
         end else if (req_in_char == CHAR_NEWLINE) begin
            gap_in = (gap_base < 2'd2) ? gap_base + 2'd1 : gap_base;
         end else begin
            gap_in = gap_base;
         end
         if (do_flush) begin
            word_length_in = '0;
            if (overlong) begin
               column_in   = 8'd0;
               stopped_in  = 1'b1;
               overflow_in = 1'b1;
            end else begin
               column_in = col_sep + 8'(flush_len);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff  <= LINE_WIDTH_RST;
         word_length_ff <= '0;
         column_ff      <= 8'd0;
         gap_ff         <= 2'd0;
         stopped_ff     <= 1'b0;
         overflow_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            line_width_ff <= csr_line_width;
         end
         word_length_ff <= word_length_in;
         column_ff      <= column_in;
         gap_ff         <= gap_in;
         stopped_ff     <= stopped_in;
         overflow_ff    <= overflow_in;
      end
   end

   gwr_ram #(
      .WIDTH (8),
      .DEPTH (MAX_WORD)
   ) u_word_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (word_length_ff[IDX_W-1:0]),
      .wr_data (req_in_char),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   gwr_emit #(
      .MAX_WORD (MAX_WORD),
      .IDX_W    (IDX_W),
      .LEN_W    (LEN_W)
   ) u_emit (
      .clock             (clock),
      .reset             (reset),
      .job               (job),
      .job_length        (flush_len),
      .busy              (emit_busy),
      .rd_addr           (rd_addr),
      .rd_data           (rd_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_char      (rsp_out_char),
      .rsp_run_last      (rsp_run_last),
      .rsp_word_exceeded (rsp_word_exceeded)
   );

   assign req_stall = emit_busy;
   assign csr_ready = 1'b1;

   // a flush starts the sequencer right away
   assert property (@(posedge clock) disable iff (reset) job.start |=> emit_busy)
      else $error("flush did not start the sequencer");

   // a halted block never has an open flush
   assert property (@(posedge clock) disable iff (reset) stopped_ff |-> !job.start)
      else $error("flush while halted");

   // halting always comes with the sticky flag
   assert property (@(posedge clock) disable iff (reset) stopped_ff |-> overflow_ff)
      else $error("halted without exceeded flag");

   // the word buffer never runs past its depth
   assert property (@(posedge clock) disable iff (reset) word_length_ff <= MAX_LEN)
      else $error("word length beyond buffer");

   // the word buffer is empty after every flush
   assert property (@(posedge clock) disable iff (reset) job.start |=> word_length_ff == '0)
      else $error("word not cleared after flush");

endmodule

// File: hdl/gwr_ram.sv
// ----------------------------------------------------------------------------
// gwr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module gwr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 48
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/gwr_emit.sv
// ----------------------------------------------------------------------------
// gwr_emit
// Output sequencer: plays out separator, buffered word and (for an overlong word)
// trailing newline of one flush into the result register, one byte at a time.
// ----------------------------------------------------------------------------
module gwr_emit import gwr_pkg::*; #(
   parameter int MAX_WORD = MAX_WORD_DEF,
   parameter int IDX_W    = $clog2(MAX_WORD),
   parameter int LEN_W    = $clog2(MAX_WORD + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  flush_job_type    job,
   input  logic [LEN_W-1:0] job_length,
   output logic             busy,
   output logic [IDX_W-1:0] rd_addr,
   input  logic [7:0]       rd_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_out_char,
   output logic             rsp_run_last,
   output logic             rsp_word_exceeded
);

   emit_state_type   state_ff, state_in;
   logic [1:0]       sep_count_ff, sep_count_in;
   logic             sep_newline_ff;
   logic             overlong_ff;
   logic             exceeded_ff;
   logic [LEN_W-1:0] length_ff;
   logic [IDX_W-1:0] idx_ff, idx_in;

   logic             rsp_valid_ff;
   logic [7:0]       rsp_char_ff;
   logic             rsp_last_ff;
   logic             rsp_exceeded_ff;

   logic             out_free;
   logic             push;
   logic [7:0]       push_char;
   logic             push_last;
   logic             at_last_byte;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign at_last_byte = (LEN_W'(idx_ff) + LEN_W'(1)) == length_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         EMIT_IDLE: begin
            if (job.start) begin
               state_in = (job.sep_count != 2'd0) ? EMIT_SEP : EMIT_READ;
            end
         end
         EMIT_SEP: begin
            if (out_free && sep_count_ff == 2'd1) begin
               state_in = EMIT_READ;
            end
         end
         EMIT_READ: begin
            state_in = EMIT_WORD;
         end
         EMIT_WORD: begin
            if (out_free) begin
               if (!at_last_byte) begin
                  state_in = EMIT_READ;
               end else if (overlong_ff) begin
                  state_in = EMIT_TAIL;
               end else begin
                  state_in = EMIT_IDLE;
               end
            end
         end
         EMIT_TAIL: begin
            if (out_free) begin
               state_in = EMIT_IDLE;
            end
         end
         default: begin
            state_in = EMIT_IDLE;
         end
      endcase
   end

   // outputs and counters
   always_comb begin
      push         = 1'b0;
      push_char    = CHAR_NEWLINE;
      push_last    = 1'b0;
      sep_count_in = sep_count_ff;
      idx_in       = idx_ff;
      case (state_ff)
         EMIT_IDLE: begin
            sep_count_in = job.sep_count;
            idx_in       = '0;
         end
         EMIT_SEP: begin
            push      = out_free;
            push_char = sep_newline_ff ? CHAR_NEWLINE : CHAR_SPACE;
            if (out_free) begin
               sep_count_in = sep_count_ff - 2'd1;
            end
         end
         EMIT_READ: begin
            push = 1'b0;
         end
         EMIT_WORD: begin
            push      = out_free;
            push_char = rd_data;
            push_last = at_last_byte && !overlong_ff;
            if (out_free && !at_last_byte) begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         EMIT_TAIL: begin
            push      = out_free;
            push_char = CHAR_NEWLINE;
            push_last = 1'b1;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= EMIT_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      sep_count_ff <= sep_count_in;
      idx_ff       <= idx_in;
      if (state_ff == EMIT_IDLE && job.start) begin
         sep_newline_ff <= job.sep_newline;
         overlong_ff    <= job.overlong;
         exceeded_ff    <= job.exceeded;
         length_ff      <= job_length;
      end
      if (push) begin
         rsp_char_ff     <= push_char;
         rsp_last_ff     <= push_last;
         rsp_exceeded_ff <= exceeded_ff;
      end
   end

   assign busy              = state_ff != EMIT_IDLE;
   assign rd_addr           = idx_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_char      = rsp_char_ff;
   assign rsp_run_last      = rsp_last_ff;
   assign rsp_word_exceeded = rsp_exceeded_ff;

endmodule
